FILE: hw/rtl/fijm_pkg.sv
// fijm_pkg: shared widths, constants and helper functions for the frame interval jitter monitor
`timescale 1ns / 1ps
package fijm_pkg;

    localparam int TS_W       = 63;   // timestamp width
    localparam int FREQ_W     = 32;   // tick frequency width
    localparam int SUM_W      = 64;   // running sum width
    localparam int CNT_W      = 32;   // sample count width
    localparam int OUT_W      = 32;   // result statistic width
    localparam int ALU_W      = 84;   // shared adder width
    localparam int DIVD_W     = 83;   // dividend width, holds ticks * 10^6
    localparam int DIVS_W     = 32;   // divisor width
    localparam int DIV_CNT_W  = 7;    // step counter width for DIVD_W steps
    localparam int US_SHIFT   = 20;   // leading term of 10^6 = 2^20 - 2^16 + 2^14 + 2^9 + 2^6
    localparam int MUL_STEPS  = 4;    // remaining terms of the decomposition
    localparam int MUL_IDX_W  = 2;
    localparam int EMA_SHIFT  = 3;    // smoothing divides by 8

    localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd10000000;

    // shift amount of each correction term of the times-10^6 product
    function automatic logic [4:0] mul_shift(input logic [MUL_IDX_W-1:0] idx);
        logic [4:0] sh;
        unique case (idx)
            2'd0:    sh = 5'd16;
            2'd1:    sh = 5'd14;
            2'd2:    sh = 5'd9;
            default: sh = 5'd6;
        endcase
        return sh;
    endfunction

    // only the 2^16 term is subtracted
    function automatic logic mul_is_sub(input logic [MUL_IDX_W-1:0] idx);
        return (idx == 2'd0);
    endfunction

endpackage

FILE: hw/rtl/fijm_alu.sv
// fijm_alu: shared wide adder / subtractor used by the sequencer
`timescale 1ns / 1ps
module fijm_alu (
    input  logic [fijm_pkg::ALU_W-1:0] op_a,
    input  logic [fijm_pkg::ALU_W-1:0] op_b,
    input  logic                       op_sub,
    output logic [fijm_pkg::ALU_W-1:0] result
);

    logic [fijm_pkg::ALU_W-1:0] b_eff;

    assign b_eff  = op_sub ? ~op_b : op_b;
    assign result = op_a + b_eff + {{(fijm_pkg::ALU_W-1){1'b0}}, op_sub};

endmodule

FILE: hw/rtl/fijm_div.sv
// fijm_div: restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module fijm_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [fijm_pkg::DIVD_W-1:0] dividend,
    input  logic [fijm_pkg::DIVS_W-1:0] divisor,
    output logic                        done,
    output logic [fijm_pkg::DIVD_W-1:0] quotient
);

    logic [fijm_pkg::DIVD_W-1:0]    quo_reg;
    logic [fijm_pkg::DIVS_W-1:0]    rem_reg;
    logic [fijm_pkg::DIVS_W-1:0]    dsor_reg;
    logic [fijm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [fijm_pkg::DIVS_W:0]      trial;
    logic [fijm_pkg::DIVS_W+1:0]    diff;
    logic                           q_bit;
    logic [fijm_pkg::DIVS_W-1:0]    rem_next;

    assign trial    = {rem_reg, quo_reg[fijm_pkg::DIVD_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, dsor_reg};
    assign q_bit    = ~diff[fijm_pkg::DIVS_W+1];
    assign rem_next = q_bit ? diff[fijm_pkg::DIVS_W-1:0] : trial[fijm_pkg::DIVS_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // pulse after the last quotient bit
            done_reg <= busy_reg && !start && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= fijm_pkg::DIV_CNT_W'(fijm_pkg::DIVD_W - 1);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsor_reg <= divisor;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[fijm_pkg::DIVD_W-2:0], q_bit};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/frame_interval_jitter_monitor.sv
// frame_interval_jitter_monitor: top level, sequencer around a shared adder and divider
`timescale 1ns / 1ps
// sequence up to m_valid: an ignored or first word goes from idle to the output register; a word
//   not later than the previous passes the subtraction first; one that yields no sample after
//   conversion ends there; a counted word runs four 83-step divisions (two tick-to-us, two means)
// throughput: one word in flight, s_ready is high only in the idle state; a finished
//   result waits in the output register while the next word is taken
// reset: aresetn synchronous active low, clears statistics, tick frequency back to 10 MHz
module frame_interval_jitter_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: tick frequency
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [62:0] s_frame_timestamp,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_counted,
    output logic [31:0] m_interval_avg_us,
    output logic [31:0] m_jitter_avg_us,
    output logic [31:0] m_jitter_max_us
);

    typedef enum logic [3:0] {
        ST_IDLE,      // wait for a word
        ST_DIFF,      // interval = ts - previous
        ST_MUL,       // times 10^6 by shift and add
        ST_DIV_GO,    // launch the divider
        ST_DIV_WAIT,  // wait for the quotient
        ST_ISUM,      // accumulate interval, bump count, seed smoothing
        ST_EMA1,      // 7 * smoothed
        ST_EMA2,      // (7 * smoothed + interval) / 8
        ST_JDIFF,     // interval - smoothed
        ST_JNEG,      // smoothed - interval when the difference went negative
        ST_JSUM,      // accumulate jitter and peak
        ST_FIN        // hand the result to the output register
    } state_t;

    // what the running division is for
    typedef enum logic [1:0] {
        PH_IV,
        PH_JIT,
        PH_AVG_I,
        PH_AVG_J
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg;

    // configuration and statistics
    logic [fijm_pkg::FREQ_W-1:0]    freq_reg;
    logic [fijm_pkg::TS_W-1:0]      ts_reg;
    logic [fijm_pkg::TS_W-1:0]      prev_reg;
    logic [fijm_pkg::SUM_W-1:0]     isum_reg;
    logic [fijm_pkg::CNT_W-1:0]     cnt_reg;
    logic [fijm_pkg::TS_W-1:0]      smooth_reg;
    logic [fijm_pkg::SUM_W-1:0]     jsum_reg;
    logic [fijm_pkg::OUT_W-1:0]     peak_reg;

    // working registers: oper holds the interval, later the jitter, in ticks
    logic [fijm_pkg::TS_W-1:0]      oper_reg;
    logic [fijm_pkg::ALU_W-1:0]     acc_reg;
    logic [fijm_pkg::MUL_IDX_W-1:0] mul_idx_reg;
    logic                           counted_reg;
    logic [fijm_pkg::OUT_W-1:0]     avg_i_reg;
    logic [fijm_pkg::OUT_W-1:0]     avg_j_reg;

    // output register
    logic                           m_valid_reg;
    logic                           m_counted_reg;
    logic [fijm_pkg::OUT_W-1:0]     m_interval_avg_us_reg;
    logic [fijm_pkg::OUT_W-1:0]     m_jitter_avg_us_reg;
    logic [fijm_pkg::OUT_W-1:0]     m_jitter_max_us_reg;

    // shared adder
    logic [fijm_pkg::ALU_W-1:0]     alu_a, alu_b, alu_y;
    logic                           alu_sub;
    logic                           alu_neg;
    logic                           sum_ovf;
    logic [fijm_pkg::SUM_W-1:0]     sum_sat;

    // divider
    logic                           div_start;
    logic                           div_done;
    logic [fijm_pkg::DIVD_W-1:0]    div_dividend;
    logic [fijm_pkg::DIVS_W-1:0]    div_divisor;
    logic [fijm_pkg::DIVD_W-1:0]    div_quo;
    logic [fijm_pkg::SUM_W-1:0]     quo_sat64;
    logic [fijm_pkg::OUT_W-1:0]     quo_sat32;

    logic                           accept;
    logic                           out_free;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    fijm_alu u_alu (
        .op_a   (alu_a),
        .op_b   (alu_b),
        .op_sub (alu_sub),
        .result (alu_y)
    );

    // top bit set means the subtraction went below zero
    assign alu_neg = alu_y[fijm_pkg::ALU_W-1];
    // 64-bit sums saturate on carry out
    assign sum_ovf = alu_y[fijm_pkg::SUM_W];
    assign sum_sat = sum_ovf ? '1 : alu_y[fijm_pkg::SUM_W-1:0];

    // conversions saturate at 64 bits, means at 32 bits
    assign quo_sat64 = (div_quo[fijm_pkg::DIVD_W-1:fijm_pkg::SUM_W] != '0) ? '1
                     : div_quo[fijm_pkg::SUM_W-1:0];
    assign quo_sat32 = (div_quo[fijm_pkg::DIVD_W-1:fijm_pkg::OUT_W] != '0) ? '1
                     : div_quo[fijm_pkg::OUT_W-1:0];

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_DIFF: begin
                alu_a   = fijm_pkg::ALU_W'(ts_reg);
                alu_b   = fijm_pkg::ALU_W'(prev_reg);
                alu_sub = 1'b1;
            end
            ST_MUL: begin
                alu_a   = acc_reg;
                alu_b   = fijm_pkg::ALU_W'(oper_reg) << fijm_pkg::mul_shift(mul_idx_reg);
                alu_sub = fijm_pkg::mul_is_sub(mul_idx_reg);
            end
            ST_ISUM: begin
                alu_a = fijm_pkg::ALU_W'(isum_reg);
                alu_b = fijm_pkg::ALU_W'(quo_sat64);
            end
            ST_EMA1: begin
                // 8s - s
                alu_a   = fijm_pkg::ALU_W'(smooth_reg) << fijm_pkg::EMA_SHIFT;
                alu_b   = fijm_pkg::ALU_W'(smooth_reg);
                alu_sub = 1'b1;
            end
            ST_EMA2: begin
                alu_a = acc_reg;
                alu_b = fijm_pkg::ALU_W'(oper_reg);
            end
            ST_JDIFF: begin
                alu_a   = fijm_pkg::ALU_W'(oper_reg);
                alu_b   = fijm_pkg::ALU_W'(smooth_reg);
                alu_sub = 1'b1;
            end
            ST_JNEG: begin
                alu_a   = fijm_pkg::ALU_W'(smooth_reg);
                alu_b   = fijm_pkg::ALU_W'(oper_reg);
                alu_sub = 1'b1;
            end
            ST_JSUM: begin
                alu_a = fijm_pkg::ALU_W'(jsum_reg);
                alu_b = fijm_pkg::ALU_W'(quo_sat64);
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    // divider operands follow the phase set before launch
    always_comb begin
        unique case (phase_reg)
            PH_IV, PH_JIT: begin
                div_dividend = acc_reg[fijm_pkg::DIVD_W-1:0];
                div_divisor  = freq_reg;
            end
            PH_AVG_I: begin
                div_dividend = fijm_pkg::DIVD_W'(isum_reg);
                div_divisor  = cnt_reg;
            end
            default: begin
                div_dividend = fijm_pkg::DIVD_W'(jsum_reg);
                div_divisor  = cnt_reg;
            end
        endcase
    end

    assign div_start = (state_reg == ST_DIV_GO);

    fijm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_frame_timestamp == '0 || freq_reg == '0 || prev_reg == '0) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                // no sample unless the timestamp moved forward
                if (alu_neg || alu_y == '0) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_idx_reg == fijm_pkg::MUL_IDX_W'(fijm_pkg::MUL_STEPS - 1)) begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    unique case (phase_reg)
                        PH_IV:    state_next = (div_quo == '0) ? ST_FIN : ST_ISUM;
                        PH_JIT:   state_next = ST_JSUM;
                        PH_AVG_I: state_next = ST_DIV_GO;
                        default:  state_next = ST_FIN;
                    endcase
                end
            end
            ST_ISUM:  state_next = (smooth_reg == '0) ? ST_JDIFF : ST_EMA1;
            ST_EMA1:  state_next = ST_EMA2;
            ST_EMA2:  state_next = ST_JDIFF;
            ST_JDIFF: state_next = alu_neg ? ST_JNEG : ST_MUL;
            ST_JNEG:  state_next = ST_MUL;
            ST_JSUM:  state_next = ST_DIV_GO;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_IV;
            freq_reg    <= fijm_pkg::FREQ_RESET;
            prev_reg    <= '0;
            isum_reg    <= '0;
            cnt_reg     <= '0;
            smooth_reg  <= '0;
            jsum_reg    <= '0;
            peak_reg    <= '0;
            avg_i_reg   <= '0;
            avg_j_reg   <= '0;
            counted_reg <= 1'b0;
            mul_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // the user must write configuration only while idle; the block does not enforce this and writes plainly
            if (cfg_we) begin
                freq_reg <= cfg_wdata;
            end

            // result word leaves the output register unless the next one lands now
            if (m_valid_reg && m_ready && state_reg != ST_FIN) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        counted_reg <= 1'b0;
                        ts_reg      <= s_frame_timestamp;
                        // first valid timestamp only becomes the previous one
                        if (s_frame_timestamp != '0 && freq_reg != '0 && prev_reg == '0) begin
                            prev_reg <= s_frame_timestamp;
                        end
                    end
                end
                ST_DIFF: begin
                    prev_reg <= ts_reg;
                    if (!(alu_neg || alu_y == '0)) begin
                        oper_reg    <= alu_y[fijm_pkg::TS_W-1:0];
                        acc_reg     <= fijm_pkg::ALU_W'(alu_y[fijm_pkg::TS_W-1:0])
                                       << fijm_pkg::US_SHIFT;
                        mul_idx_reg <= '0;
                        phase_reg   <= PH_IV;
                    end
                end
                ST_MUL: begin
                    acc_reg     <= alu_y;
                    mul_idx_reg <= mul_idx_reg + 1'b1;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        if (phase_reg == PH_AVG_I) begin
                            avg_i_reg <= quo_sat32;
                            phase_reg <= PH_AVG_J;
                        end else if (phase_reg == PH_AVG_J) begin
                            avg_j_reg <= quo_sat32;
                        end
                    end
                end
                ST_ISUM: begin
                    counted_reg <= 1'b1;
                    isum_reg    <= sum_sat;
                    if (cnt_reg != '1) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    // first sample seeds the smoothed interval
                    if (smooth_reg == '0) begin
                        smooth_reg <= oper_reg;
                    end
                end
                ST_EMA1: begin
                    acc_reg <= alu_y;
                end
                ST_EMA2: begin
                    smooth_reg <= alu_y[fijm_pkg::TS_W+fijm_pkg::EMA_SHIFT-1:fijm_pkg::EMA_SHIFT];
                end
                ST_JDIFF, ST_JNEG: begin
                    if (!(state_reg == ST_JDIFF && alu_neg)) begin
                        oper_reg    <= alu_y[fijm_pkg::TS_W-1:0];
                        acc_reg     <= fijm_pkg::ALU_W'(alu_y[fijm_pkg::TS_W-1:0])
                                       << fijm_pkg::US_SHIFT;
                        mul_idx_reg <= '0;
                        phase_reg   <= PH_JIT;
                    end
                end
                ST_JSUM: begin
                    jsum_reg <= sum_sat;
                    if (quo_sat64 > fijm_pkg::SUM_W'(peak_reg)) begin
                        peak_reg <= (quo_sat64[fijm_pkg::SUM_W-1:fijm_pkg::OUT_W] != '0) ? '1
                                  : quo_sat64[fijm_pkg::OUT_W-1:0];
                    end
                    phase_reg <= PH_AVG_I;
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_valid_reg           <= 1'b1;
                        m_counted_reg         <= counted_reg;
                        m_interval_avg_us_reg <= avg_i_reg;
                        m_jitter_avg_us_reg   <= avg_j_reg;
                        m_jitter_max_us_reg   <= peak_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_counted         = m_counted_reg;
    assign m_interval_avg_us = m_interval_avg_us_reg;
    assign m_jitter_avg_us   = m_jitter_avg_us_reg;
    assign m_jitter_max_us   = m_jitter_max_us_reg;

endmodule
